// ===== design/assert_macros.svh =====
// Assertion macros included by the encoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/mtce_pkg.sv =====
// Types, codes and helper functions of the MIDI track chunk encoder.
package mtce_pkg;

    localparam int EV_W   = 55;
    localparam int TICK_W = 28;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_PULL  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE, PH_HEADER, PH_EVENTS, PH_TRAILER, PH_DONE
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE, S_SORT_I, S_SORT_KEY, S_SORT_J, S_SORT_S, S_SORT_E,
        S_LEN_I, S_LEN_S, S_LEN_E, S_LEN_END, S_HDR,
        S_PULL, S_EV_S, S_EV_E
    } t_state;

    typedef struct packed {
        logic [7:0][7:0] bytes;
        logic [3:0]      len;
    } t_section;

    function automatic logic [2:0] vlq_len(input logic [TICK_W-1:0] v);
        logic [2:0] n;
        n = 3'd1;
        if (v[27:7] != '0)  n = 3'd2;
        if (v[27:14] != '0) n = 3'd3;
        if (v[27:21] != '0) n = 3'd4;
        return n;
    endfunction

    // True when event a must be emitted after event b.
    function automatic logic sorts_after(input logic [EV_W-1:0] a, input logic [30:0] b_key);
        return {a[27:0], a[30:28]} > b_key;
    endfunction

    // VLQ of v followed by three message bytes.
    function automatic t_section make_section(input logic [TICK_W-1:0] v,
                                              input logic [7:0] b0,
                                              input logic [7:0] b1,
                                              input logic [7:0] b2);
        logic [2:0] n;
        t_section   s;
        n = vlq_len(v);
        s.bytes = '0;
        case (n)
            3'd1: begin
                s.bytes[0] = {1'b0, v[6:0]};
            end
            3'd2: begin
                s.bytes[0] = {1'b1, v[13:7]};
                s.bytes[1] = {1'b0, v[6:0]};
            end
            3'd3: begin
                s.bytes[0] = {1'b1, v[20:14]};
                s.bytes[1] = {1'b1, v[13:7]};
                s.bytes[2] = {1'b0, v[6:0]};
            end
            default: begin
                s.bytes[0] = {1'b1, v[27:21]};
                s.bytes[1] = {1'b1, v[20:14]};
                s.bytes[2] = {1'b1, v[13:7]};
                s.bytes[3] = {1'b0, v[6:0]};
            end
        endcase
        s.bytes[n]        = b0;
        s.bytes[n + 3'd1] = b1;
        s.bytes[n + 3'd2] = b2;
        s.len = {1'b0, n} + 4'd3;
        return s;
    endfunction

endpackage

// ===== design/mtce_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module mtce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/midi_track_chunk_encoder.sv =====
// Top level of the MIDI track chunk encoder: event store, sorter and byte emitter.
//
// The input stream carries one command per word: tuser selects load (0), pull (1)
// or clear (2); tdata holds the event for a load. A load appends the event to the
// store and gives no result, unless the store is full, when one word with error 1
// comes out. A clear empties the store. Each pull returns one byte of the track
// chunk: "MTrk", the 32-bit big-endian body length, the events in order of tick,
// tie order and load order as VLQ delta plus three bytes, then the end delta and
// FF 2F 00. tlast marks the final byte; a pull past it returns error 2.
// The first pull of a chunk runs an insertion sort over the store, then a length
// pass; both walk the two memories through their single read port, so that pull
// takes longest when the stored events were loaded in falling order. Later pulls
// send the next pending byte, first fetching an event from memory when the bytes
// of the last one are used up.
// One word is handled at a time; the input is not ready while a result waits in
// the output register, so a stalled receiver holds off the sender. Reset empties
// the store, clears total_tick and restarts the chunk; the memories need no
// clearing pass since only written entries are read.
`include "assert_macros.svh"

module midi_track_chunk_encoder #(
    parameter int EVENT_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [27:0] i_cfg_wdata,      // total_tick
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,     // tick, order, status_byte, first_data, second_data
    input  logic [1:0]  s_axis_tuser,     // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,     // out_byte
    output logic        m_axis_tlast,     // last_byte
    output logic [1:0]  m_axis_tuser      // error
);
    localparam int IW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
    localparam int CW = $clog2(EVENT_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(EVENT_DEPTH);

    mtce_pkg::t_state r_state, n_state;
    mtce_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_i, n_i;
    logic [CW-1:0]    r_j, n_j;
    logic [CW-1:0]    r_cursor, n_cursor;
    logic [30:0]      r_key, n_key;
    logic [IW-1:0]    r_s, n_s;
    logic [31:0]      r_len, n_len;
    logic [27:0]      r_prev, n_prev;
    logic [27:0]      r_end_delta, n_end_delta;
    logic [27:0]      r_prev_tick, n_prev_tick;
    logic [7:0][7:0]  r_pend, n_pend;
    logic [3:0]       r_pend_len, n_pend_len;
    logic [3:0]       r_pend_pos, n_pend_pos;
    logic [27:0]      r_total_tick;
    logic             r_m_valid, n_m_valid;
    logic [7:0]       r_m_data, n_m_data;
    logic             r_m_last, n_m_last;
    logic [1:0]       r_m_user, n_m_user;

    // Memory ports.
    logic                      ev_we;
    logic [IW-1:0]             ev_waddr, ev_raddr;
    logic [mtce_pkg::EV_W-1:0] ev_rdata;
    logic                      ix_we;
    logic [IW-1:0]             ix_waddr, ix_wdata, ix_raddr, ix_rdata;

    logic                      accept;
    logic [27:0]               ending;
    logic [27:0]               delta;
    mtce_pkg::t_section        sec;

    mtce_ram #(.WIDTH(mtce_pkg::EV_W), .DEPTH(EVENT_DEPTH)) u_event_store (
        .i_clk  (i_clk),
        .i_we   (ev_we),
        .i_waddr(ev_waddr),
        .i_wdata(s_axis_tdata[mtce_pkg::EV_W-1:0]),
        .i_raddr(ev_raddr),
        .o_rdata(ev_rdata)
    );

    mtce_ram #(.WIDTH(IW), .DEPTH(EVENT_DEPTH)) u_sorted_index (
        .i_clk  (i_clk),
        .i_we   (ix_we),
        .i_waddr(ix_waddr),
        .i_wdata(ix_wdata),
        .i_raddr(ix_raddr),
        .o_rdata(ix_rdata)
    );

    assign s_axis_tready = (r_state == mtce_pkg::S_IDLE) && !r_m_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = r_m_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mtce_pkg::S_IDLE;
            r_phase      <= mtce_pkg::PH_IDLE;
            r_count      <= '0;
            r_m_valid    <= 1'b0;
            r_total_tick <= '0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                r_total_tick <= i_cfg_wdata;
            end
        end
        r_i         <= n_i;
        r_j         <= n_j;
        r_cursor    <= n_cursor;
        r_key       <= n_key;
        r_s         <= n_s;
        r_len       <= n_len;
        r_prev      <= n_prev;
        r_end_delta <= n_end_delta;
        r_prev_tick <= n_prev_tick;
        r_pend      <= n_pend;
        r_pend_len  <= n_pend_len;
        r_pend_pos  <= n_pend_pos;
        r_m_data    <= n_m_data;
        r_m_last    <= n_m_last;
        r_m_user    <= n_m_user;
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_count     = r_count;
        n_i         = r_i;
        n_j         = r_j;
        n_cursor    = r_cursor;
        n_key       = r_key;
        n_s         = r_s;
        n_len       = r_len;
        n_prev      = r_prev;
        n_end_delta = r_end_delta;
        n_prev_tick = r_prev_tick;
        n_pend      = r_pend;
        n_pend_len  = r_pend_len;
        n_pend_pos  = r_pend_pos;
        n_m_valid   = r_m_valid && !m_axis_tready;
        n_m_data    = r_m_data;
        n_m_last    = r_m_last;
        n_m_user    = r_m_user;
        ev_we       = 1'b0;
        ev_waddr    = r_count[IW-1:0];
        ev_raddr    = r_i[IW-1:0];
        ix_we       = 1'b0;
        ix_waddr    = r_j[IW-1:0];
        ix_wdata    = r_i[IW-1:0];
        ix_raddr    = r_i[IW-1:0];
        ending      = (r_total_tick > r_prev) ? r_total_tick : r_prev;
        delta       = ev_rdata[27:0] - r_prev_tick;
        sec         = mtce_pkg::make_section(r_end_delta, 8'hff, 8'h2f, 8'h00);

        case (r_state)
            mtce_pkg::S_IDLE: begin
                if (accept) begin
                    case (s_axis_tuser)
                        mtce_pkg::OP_LOAD: begin
                            if (r_count == FULL) begin
                                n_m_valid = 1'b1;
                                n_m_data  = '0;
                                n_m_last  = 1'b0;
                                n_m_user  = mtce_pkg::ERR_FULL;
                            end else begin
                                ev_we   = 1'b1;
                                n_count = r_count + 1'b1;
                                n_phase = mtce_pkg::PH_IDLE;
                            end
                        end
                        mtce_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_phase = mtce_pkg::PH_IDLE;
                        end
                        mtce_pkg::OP_PULL: begin
                            if (r_phase == mtce_pkg::PH_IDLE) begin
                                n_i     = '0;
                                n_state = mtce_pkg::S_SORT_I;
                            end else begin
                                n_state = mtce_pkg::S_PULL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Insertion sort of load positions into the index memory.
            mtce_pkg::S_SORT_I: begin
                if (r_i == r_count) begin
                    n_i     = '0;
                    n_prev  = '0;
                    n_len   = '0;
                    n_state = mtce_pkg::S_LEN_I;
                end else begin
                    n_j     = r_i;
                    n_state = mtce_pkg::S_SORT_KEY;
                end
            end
            mtce_pkg::S_SORT_KEY: begin
                n_key   = {ev_rdata[27:0], ev_rdata[30:28]};
                n_state = mtce_pkg::S_SORT_J;
            end
            mtce_pkg::S_SORT_J: begin
                ix_raddr = IW'(r_j - 1'b1);
                if (r_j == '0) begin
                    ix_we   = 1'b1;
                    n_i     = r_i + 1'b1;
                    n_state = mtce_pkg::S_SORT_I;
                end else begin
                    n_state = mtce_pkg::S_SORT_S;
                end
            end
            mtce_pkg::S_SORT_S: begin
                n_s      = ix_rdata;
                ev_raddr = ix_rdata;
                n_state  = mtce_pkg::S_SORT_E;
            end
            mtce_pkg::S_SORT_E: begin
                ix_we = 1'b1;
                if (mtce_pkg::sorts_after(ev_rdata, r_key)) begin
                    ix_wdata = r_s;
                    n_j      = r_j - 1'b1;
                    n_state  = mtce_pkg::S_SORT_J;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = mtce_pkg::S_SORT_I;
                end
            end
            // Body length pass over the sorted order.
            mtce_pkg::S_LEN_I: begin
                if (r_i == r_count) begin
                    n_state = mtce_pkg::S_LEN_END;
                end else begin
                    n_state = mtce_pkg::S_LEN_S;
                end
            end
            mtce_pkg::S_LEN_S: begin
                ev_raddr = ix_rdata;
                n_state  = mtce_pkg::S_LEN_E;
            end
            mtce_pkg::S_LEN_E: begin
                n_len   = r_len + 32'(mtce_pkg::vlq_len(ev_rdata[27:0] - r_prev)) + 32'd3;
                n_prev  = ev_rdata[27:0];
                n_i     = r_i + 1'b1;
                n_state = mtce_pkg::S_LEN_I;
            end
            mtce_pkg::S_LEN_END: begin
                n_end_delta = ending - r_prev;
                n_state     = mtce_pkg::S_HDR;
            end
            mtce_pkg::S_HDR: begin
                n_len       = r_len + 32'(mtce_pkg::vlq_len(r_end_delta)) + 32'd3;
                n_pend[0]   = 8'h4d;
                n_pend[1]   = 8'h54;
                n_pend[2]   = 8'h72;
                n_pend[3]   = 8'h6b;
                n_pend[4]   = n_len[31:24];
                n_pend[5]   = n_len[23:16];
                n_pend[6]   = n_len[15:8];
                n_pend[7]   = n_len[7:0];
                n_pend_len  = 4'd8;
                n_pend_pos  = '0;
                n_cursor    = '0;
                n_prev_tick = '0;
                n_phase     = mtce_pkg::PH_HEADER;
                n_state     = mtce_pkg::S_PULL;
            end
            mtce_pkg::S_PULL: begin
                ix_raddr = r_cursor[IW-1:0];
                if (r_phase != mtce_pkg::PH_DONE && r_pend_pos >= r_pend_len) begin
                    if (r_phase == mtce_pkg::PH_TRAILER) begin
                        n_phase = mtce_pkg::PH_DONE;
                    end else if (r_cursor < r_count) begin
                        n_state = mtce_pkg::S_EV_S;
                    end else begin
                        n_pend     = sec.bytes;
                        n_pend_len = sec.len;
                        n_pend_pos = '0;
                        n_phase    = mtce_pkg::PH_TRAILER;
                    end
                end else if (r_phase == mtce_pkg::PH_DONE) begin
                    n_m_valid = 1'b1;
                    n_m_data  = '0;
                    n_m_last  = 1'b0;
                    n_m_user  = mtce_pkg::ERR_EMPTY;
                    n_state   = mtce_pkg::S_IDLE;
                end else begin
                    n_m_valid  = 1'b1;
                    n_m_data   = r_pend[r_pend_pos[2:0]];
                    n_pend_pos = r_pend_pos + 1'b1;
                    n_m_last   = (r_phase == mtce_pkg::PH_TRAILER) && (n_pend_pos >= r_pend_len);
                    n_m_user   = mtce_pkg::ERR_NONE;
                    n_state    = mtce_pkg::S_IDLE;
                end
            end
            mtce_pkg::S_EV_S: begin
                ev_raddr = ix_rdata;
                n_state  = mtce_pkg::S_EV_E;
            end
            mtce_pkg::S_EV_E: begin
                sec         = mtce_pkg::make_section(delta, ev_rdata[38:31],
                                                     ev_rdata[46:39], ev_rdata[54:47]);
                n_pend      = sec.bytes;
                n_pend_len  = sec.len;
                n_pend_pos  = '0;
                n_prev_tick = ev_rdata[27:0];
                n_cursor    = r_cursor + 1'b1;
                n_phase     = mtce_pkg::PH_EVENTS;
                n_state     = mtce_pkg::S_PULL;
            end
            default: begin
                n_state = mtce_pkg::S_IDLE;
            end
        endcase
    end

    // The event count never passes the store depth.
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= FULL)
    // An error word carries no byte and no end mark.
    `ASSERT_IMPLIES(a_err_clean, i_clk, i_rst_n, r_m_valid && r_m_user != mtce_pkg::ERR_NONE, r_m_data == 8'd0 && !r_m_last)
    // A load into a store with room adds exactly one event.
    `ASSERT_NEXT(a_load_count, i_clk, i_rst_n, accept && s_axis_tuser == mtce_pkg::OP_LOAD && r_count != FULL, r_count == $past(r_count) + 1'b1)
endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the MIDI track chunk encoder, with a behavioural chunk predictor.
module tb;

    // Operation code that the block ignores.
    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int DEPTH = 256;
    localparam logic [27:0] TICK_MAX = 28'h0fffffff;

    typedef struct packed {
        logic [27:0] tick;
        logic [2:0]  rank;
        logic [7:0]  status_b;
        logic [7:0]  first_b;
        logic [7:0]  second_b;
    } t_midi_event;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] err;
    } t_chunk_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [27:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    midi_track_chunk_encoder #(.EVENT_DEPTH(DEPTH)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: its own copy of the store, the register and the chunk being sent.
    t_midi_event stored_events[DEPTH];
    int          stored_count = 0;
    logic [27:0] track_length = '0;
    bit          chunk_open = 1'b0;
    logic [7:0]  chunk_bytes[$];
    int          chunk_pos = 0;
    t_chunk_word expected_words[$];
    int          failures = 0;
    bit          quiet = 1'b0;
    int          items_sent = 0;

    // Appends one byte to the end of the chunk.
    function automatic void add_byte(input logic [7:0] b);
        chunk_bytes = {chunk_bytes, b};
    endfunction

    // Appends one expected output word.
    function automatic void add_word(input logic [7:0] d, input logic l, input logic [1:0] e);
        t_chunk_word w;
        w.data = d;
        w.last = l;
        w.err  = e;
        expected_words = {expected_words, w};
    endfunction

    // Appends a variable-length quantity, most significant group first.
    function automatic void push_vlq(input logic [27:0] v);
        int n;
        logic [7:0] b;
        n = 1;
        if (v[27:7] != '0)  n = 2;
        if (v[27:14] != '0) n = 3;
        if (v[27:21] != '0) n = 4;
        for (int i = 0; i < n; i++) begin
            b = {1'b0, 7'((v >> (7 * (n - 1 - i))) & 28'h7f)};
            if (i < n - 1) b[7] = 1'b1;
            add_byte(b);
        end
    endfunction

    // Builds the whole chunk: stable sort by tick then rank, so ties keep load order.
    function automatic void build_chunk();
        int          order_idx[DEPTH];
        int          j;
        logic [27:0] prev;
        logic [27:0] ending;
        logic [31:0] body_len;
        t_midi_event e;
        for (int i = 0; i < stored_count; i++) begin
            j = i;
            while (j > 0 && {stored_events[order_idx[j-1]].tick, stored_events[order_idx[j-1]].rank}
                   > {stored_events[i].tick, stored_events[i].rank}) begin
                order_idx[j] = order_idx[j-1];
                j--;
            end
            order_idx[j] = i;
        end
        chunk_bytes.delete();
        prev = '0;
        for (int i = 0; i < stored_count; i++) begin
            e = stored_events[order_idx[i]];
            push_vlq(e.tick - prev);
            add_byte(e.status_b);
            add_byte(e.first_b);
            add_byte(e.second_b);
            prev = e.tick;
        end
        ending = (track_length > prev) ? track_length : prev;
        push_vlq(ending - prev);
        add_byte(8'hff);
        add_byte(8'h2f);
        add_byte(8'h00);
        body_len = 32'(chunk_bytes.size());
        chunk_bytes.push_front(body_len[7:0]);
        chunk_bytes.push_front(body_len[15:8]);
        chunk_bytes.push_front(body_len[23:16]);
        chunk_bytes.push_front(body_len[31:24]);
        chunk_bytes.push_front("k");
        chunk_bytes.push_front("r");
        chunk_bytes.push_front("T");
        chunk_bytes.push_front("M");
        chunk_pos = 0;
        chunk_open = 1'b1;
    endfunction

    function automatic void predict_word(input logic [1:0] op, input t_midi_event ev);
        case (op)
            mtce_pkg::OP_LOAD: begin
                if (stored_count >= DEPTH) begin
                    add_word(8'h00, 1'b0, mtce_pkg::ERR_FULL);
                end else begin
                    stored_events[stored_count] = ev;
                    stored_count++;
                    chunk_open = 1'b0;
                end
            end
            mtce_pkg::OP_CLEAR: begin
                stored_count = 0;
                chunk_open = 1'b0;
            end
            mtce_pkg::OP_PULL: begin
                if (!chunk_open) build_chunk();
                if (chunk_pos >= chunk_bytes.size()) begin
                    add_word(8'h00, 1'b0, mtce_pkg::ERR_EMPTY);
                end else begin
                    add_word(chunk_bytes[chunk_pos], chunk_pos == chunk_bytes.size() - 1,
                             mtce_pkg::ERR_NONE);
                    chunk_pos++;
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Sends one word and waits for it to be taken; valid stays high into the next word
    // when there is no gap, so it is never lowered and raised in the same step.
    task automatic send_word(input logic [1:0] op, input t_midi_event ev);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, ev.second_b, ev.first_b, ev.status_b, ev.rank, ev.tick};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_word(op, ev);
        items_sent++;
    endtask

    function automatic t_midi_event random_event(input bit wide);
        t_midi_event ev;
        ev.tick     = wide ? 28'($urandom()) : 28'($urandom_range(0, 300));
        ev.rank     = 3'($urandom_range(0, 7));
        ev.status_b = 8'($urandom());
        ev.first_b  = 8'($urandom());
        ev.second_b = 8'($urandom());
        return ev;
    endfunction

    task automatic load_event(input logic [27:0] tick, input logic [2:0] rank,
                              input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
        send_word(mtce_pkg::OP_LOAD, '{tick, rank, b0, b1, b2});
    endtask

    task automatic send_op(input logic [1:0] op);
        send_word(op, random_event(1'b1));
    endtask

    // Pulls until the chunk is exhausted, then the given number of extra pulls.
    task automatic pull_chunk(input int extra);
        do send_op(mtce_pkg::OP_PULL); while (!chunk_open || chunk_pos < chunk_bytes.size());
        repeat (extra) send_op(mtce_pkg::OP_PULL);
    endtask

    // Waits until every expected word is back, then lets a loaded word settle.
    task automatic drain();
        if (s_axis_tvalid) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_track_length(input logic [27:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        track_length = value;
    endtask

    // Empty store: header, end delta and end marker only, then pulls past the end.
    task automatic test_empty_track();
        pull_chunk(2);
        write_track_length(TICK_MAX);
        send_op(mtce_pkg::OP_CLEAR);
        pull_chunk(1);
    endtask

    // Field extremes, ties, the ignored code, restart after pulling and a
    // register change in the middle of a chunk.
    task automatic test_directed();
        write_track_length(28'd0);
        send_op(mtce_pkg::OP_CLEAR);
        load_event(TICK_MAX, 3'd7, 8'hff, 8'hff, 8'hff);
        load_event(28'd0,    3'd0, 8'h00, 8'h00, 8'h00);
        load_event(28'd500,  3'd5, 8'h90, 8'h3c, 8'h40);
        load_event(28'd500,  3'd2, 8'h80, 8'h3c, 8'h00);
        load_event(28'd500,  3'd2, 8'h91, 8'h40, 8'h7f);
        send_op(OP_IGNORED);
        load_event(28'h0200000, 3'd1, 8'hc0, 8'h05, 8'h55);
        repeat (6) send_op(mtce_pkg::OP_PULL);
        load_event(28'd127, 3'd3, 8'haa, 8'h55, 8'h01);
        repeat (10) send_op(mtce_pkg::OP_PULL);
        // The new length must only apply once the chunk restarts.
        write_track_length(28'h0001000);
        pull_chunk(2);
        send_op(mtce_pkg::OP_CLEAR);
        load_event(28'd16383, 3'd4, 8'h90, 8'h01, 8'h02);
        pull_chunk(1);
        send_op(mtce_pkg::OP_CLEAR);
        pull_chunk(1);
    endtask

    // Fills the store, overflows it and reads back the head of the chunk.
    task automatic test_full_store();
        write_track_length(28'($urandom()));
        send_op(mtce_pkg::OP_CLEAR);
        for (int i = 0; i < DEPTH; i++) send_word(mtce_pkg::OP_LOAD, random_event(i % 4 == 0));
        send_word(mtce_pkg::OP_LOAD, random_event(1'b1));
        repeat (48) send_op(mtce_pkg::OP_PULL);
        send_word(mtce_pkg::OP_LOAD, random_event(1'b0));
        send_op(mtce_pkg::OP_CLEAR);
    endtask

    // Mostly well-formed tracks with random content; some noise and early restarts.
    task automatic test_random_tracks();
        int start;
        int loads;
        int pulls;
        bit paused;
        start = items_sent;
        paused = 1'b0;
        while (items_sent - start < 550) begin
            quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) == 0) write_track_length($urandom_range(0, 3) == 0 ?
                    28'($urandom()) : 28'($urandom_range(0, 2000)));
            if (!paused && items_sent - start > 275) begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(0, 3) != 0) send_op(mtce_pkg::OP_CLEAR);
            loads = $urandom_range(0, 10);
            for (int i = 0; i < loads; i++) begin
                send_word(mtce_pkg::OP_LOAD, random_event($urandom_range(0, 3) == 0));
                if ($urandom_range(0, 20) == 0) send_op(OP_IGNORED);
            end
            if ($urandom_range(0, 5) == 0) begin
                pulls = $urandom_range(1, 12);
                repeat (pulls) send_op(mtce_pkg::OP_PULL);
            end else begin
                pull_chunk($urandom_range(0, 2));
            end
        end
        quiet = 1'b0;
    endtask

    // Receiver: a fresh random stall, possibly none, before every word.
    initial begin
        int stall;
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Checks each word taken from the output against the oldest expectation.
    always @(posedge i_clk) begin
        t_chunk_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word data=%h last=%b err=%0d", $time,
                         m_axis_tdata, m_axis_tlast, m_axis_tuser);
                failures++;
            end else begin
                want = expected_words.pop_front();
                if (m_axis_tdata !== want.data) begin
                    $display("%0t: out_byte expected %h actual %h", $time, want.data,
                             m_axis_tdata);
                    failures++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: last_byte expected %b actual %b", $time, want.last,
                             m_axis_tlast);
                    failures++;
                end
                if (m_axis_tuser !== want.err) begin
                    $display("%0t: error expected %0d actual %0d", $time, want.err,
                             m_axis_tuser);
                    failures++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_track();
        test_directed();
        test_full_store();
        test_random_tracks();
        drain();
        repeat (20) @(posedge i_clk);
        if (failures == 0) begin
            $display("[midi_track_chunk_encoder] OK");
        end else begin
            $display("[midi_track_chunk_encoder] ERROR");
        end
        $finish;
    end

    initial begin
        #50000000;
        $display("[midi_track_chunk_encoder] ERROR");
        $finish;
    end

endmodule
